// ----- src/ast_pkg.sv -----
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, codes and character constants of the assembly tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int LINE_WIDTH_DEF   = 24;
  localparam int COLUMN_WIDTH_DEF = 16;

  // result field widths
  localparam int LINE_OUT_W = 24;
  localparam int COL_OUT_W  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RES     = 4;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  // token kinds
  typedef enum logic [2:0] {
    TOK_INTEGER = 3'd0,
    TOK_NUMBER  = 3'd1,
    TOK_STRING  = 3'd2,
    TOK_SYMBOL  = 3'd3,
    TOK_DOT     = 3'd4,
    TOK_AT      = 3'd5,
    TOK_COLON   = 3'd6,
    TOK_PLUS    = 3'd7
  } tok_t;

  localparam logic ERR_INVALID  = 1'b0;
  localparam logic ERR_UNCLOSED = 1'b1;

  // lexer modes
  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_COMMENT = 6'b000010,
    M_STRING  = 6'b000100,
    M_NUMBER  = 6'b001000,
    M_HELD    = 6'b010000,
    M_ERROR   = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // one result inside a bundle; post selects the counters after counting
  typedef struct packed {
    kind_t      kind;
    logic [7:0] text;
    tok_t       tok;
    logic       ec;
    logic       post;
  } res_t;

  // all results caused by one item
  typedef struct packed {
    logic [1:0]            last_idx;
    res_t [MAX_RES-1:0]    res;
    logic [LINE_OUT_W-1:0] line_pre;
    logic [COL_OUT_W-1:0]  col_pre;
    logic [LINE_OUT_W-1:0] line_post;
    logic [COL_OUT_W-1:0]  col_post;
  } bundle_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] t, tok_t tk, logic e, logic p);
    res_t r;
    r.kind = k;
    r.text = t;
    r.tok  = tk;
    r.ec   = e;
    r.post = p;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {[8'h09:8'h0D], CH_SPACE};
  endfunction

endpackage

// ----- src/ast_front.sv -----
// ----------------------------------------------------------------------------
// ast_front
// Lexer state and classification: turns one byte into a bundle of results.
// ----------------------------------------------------------------------------
module ast_front
  import ast_pkg::*;
#(
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output logic       push,
  output bundle_t    bundle
);

  mode_t                   mode_r, mode_nxt;
  logic                    sym_r, sym_nxt;
  logic [7:0]              held_r, held_nxt;
  logic                    dot_r, dot_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [COLUMN_WIDTH-1:0] col_r, col_nxt;

  logic [LINE_WIDTH-1:0]   line_cnt;
  logic [COLUMN_WIDTH-1:0] col_cnt;
  logic                    is_end;

  assign is_end = end_of_input || (char_byte == 8'h00);

  // saturating counters after this byte
  always_comb begin
    line_cnt = line_r;
    col_cnt  = col_r;
    if (char_byte == CH_NL) begin
      col_cnt = '0;
      if (line_r != {LINE_WIDTH{1'b1}}) line_cnt = line_r + 1'b1;
    end else if (col_r != {COLUMN_WIDTH{1'b1}}) begin
      col_cnt = col_r + 1'b1;
    end
  end

  always_comb begin
    logic [2:0]          n;
    logic                counted;
    logic                fresh;
    logic                was_sym;
    res_t [MAX_RES-1:0]  res;
    logic [7:0]          c;

    c        = char_byte;
    n        = '0;
    counted  = 1'b0;
    fresh    = 1'b0;
    was_sym  = 1'b0;
    res      = '0;
    mode_nxt = mode_r;
    sym_nxt  = sym_r;
    held_nxt = held_r;
    dot_nxt  = dot_r;

    if (is_end) begin
      case (mode_r)
        M_NUMBER: begin
          res[n[1:0]] = mk_res(KIND_END, 8'h00, dot_r ? TOK_NUMBER : TOK_INTEGER, 1'b0, 1'b0);
          n = n + 3'd1;
        end
        M_HELD: begin
          if (held_r == CH_MINUS) begin
            res[n[1:0]] = mk_res(KIND_ERROR, 8'h00, TOK_INTEGER, ERR_INVALID, 1'b0);
            n = n + 3'd1;
          end else begin
            res[n[1:0]] = mk_res(KIND_TEXT, held_r, TOK_INTEGER, 1'b0, 1'b0);
            n = n + 3'd1;
            res[n[1:0]] = mk_res(KIND_END, 8'h00, (held_r == CH_DOT) ? TOK_DOT : TOK_PLUS,
                                 1'b0, 1'b0);
            n = n + 3'd1;
          end
        end
        M_STRING: begin
          res[n[1:0]] = mk_res(KIND_ERROR, 8'h00, TOK_INTEGER, ERR_UNCLOSED, 1'b0);
          n = n + 3'd1;
        end
        M_IDLE: begin
          if (sym_r) begin
            res[n[1:0]] = mk_res(KIND_END, 8'h00, TOK_SYMBOL, 1'b0, 1'b0);
            n = n + 3'd1;
          end
        end
        default: ;
      endcase
      res[n[1:0]] = mk_res(KIND_DONE, 8'h00, TOK_INTEGER, 1'b0, 1'b0);
      n = n + 3'd1;
      mode_nxt = M_IDLE;
      sym_nxt  = 1'b0;
      held_nxt = '0;
      dot_nxt  = 1'b0;
    end else begin
      case (mode_r)
        M_ERROR: counted = 1'b1;
        M_COMMENT: begin
          if (c == CH_NL) fresh = 1'b1;
          else counted = 1'b1;
        end
        M_STRING: begin
          counted = 1'b1;
          if (c == CH_QUOTE) begin
            res[n[1:0]] = mk_res(KIND_END, 8'h00, TOK_STRING, 1'b0, 1'b1);
            n = n + 3'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
            n = n + 3'd1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c) || (c == CH_DOT && !dot_r)) begin
            counted = 1'b1;
            if (c == CH_DOT) dot_nxt = 1'b1;
            res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
            n = n + 3'd1;
          end else begin
            res[n[1:0]] = mk_res(KIND_END, 8'h00, dot_r ? TOK_NUMBER : TOK_INTEGER,
                                 1'b0, 1'b0);
            n = n + 3'd1;
            dot_nxt = 1'b0;
            fresh   = 1'b1;
          end
        end
        M_HELD: begin
          if (is_digit(c)) begin
            res[n[1:0]] = mk_res(KIND_TEXT, held_r, TOK_INTEGER, 1'b0, 1'b0);
            n = n + 3'd1;
            dot_nxt  = (held_r == CH_DOT);
            held_nxt = '0;
            mode_nxt = M_NUMBER;
            counted  = 1'b1;
            res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
            n = n + 3'd1;
          end else begin
            held_nxt = '0;
            mode_nxt = M_IDLE;
            if (held_r == CH_MINUS) begin
              res[n[1:0]] = mk_res(KIND_ERROR, 8'h00, TOK_INTEGER, ERR_INVALID, 1'b0);
              n = n + 3'd1;
              mode_nxt = M_ERROR;
              sym_nxt  = 1'b0;
              dot_nxt  = 1'b0;
              counted  = 1'b1;
            end else begin
              res[n[1:0]] = mk_res(KIND_TEXT, held_r, TOK_INTEGER, 1'b0, 1'b0);
              n = n + 3'd1;
              res[n[1:0]] = mk_res(KIND_END, 8'h00, (held_r == CH_DOT) ? TOK_DOT : TOK_PLUS,
                                   1'b0, 1'b0);
              n = n + 3'd1;
              fresh = 1'b1;
            end
          end
        end
        default: fresh = 1'b1;
      endcase

      // classify the byte from a clean start
      if (fresh) begin
        counted  = 1'b1;
        mode_nxt = M_IDLE;
        if (is_space(c)) begin
          if (sym_nxt) begin
            res[n[1:0]] = mk_res(KIND_END, 8'h00, TOK_SYMBOL, 1'b0, 1'b1);
            n = n + 3'd1;
          end
          sym_nxt = 1'b0;
        end else if (sym_nxt && (is_digit(c) || is_alpha(c))) begin
          res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
          n = n + 3'd1;
        end else if (c == CH_MINUS && sym_nxt) begin
          res[n[1:0]] = mk_res(KIND_ERROR, 8'h00, TOK_INTEGER, ERR_INVALID, 1'b1);
          n = n + 3'd1;
          mode_nxt = M_ERROR;
          sym_nxt  = 1'b0;
          held_nxt = '0;
          dot_nxt  = 1'b0;
        end else if (c inside {CH_HASH, CH_QUOTE, CH_DOT, CH_PLUS, CH_AT, CH_COLON}) begin
          was_sym = sym_nxt;
          if (sym_nxt) begin
            res[n[1:0]] = mk_res(KIND_END, 8'h00, TOK_SYMBOL, 1'b0, 1'b1);
            n = n + 3'd1;
          end
          sym_nxt = 1'b0;
          if (c == CH_HASH) begin
            mode_nxt = M_COMMENT;
          end else if (c == CH_QUOTE) begin
            mode_nxt = M_STRING;
          end else if (c == CH_AT || c == CH_COLON) begin
            res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
            n = n + 3'd1;
            res[n[1:0]] = mk_res(KIND_END, 8'h00, (c == CH_AT) ? TOK_AT : TOK_COLON,
                                 1'b0, 1'b1);
            n = n + 3'd1;
          end else if (was_sym) begin
            res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
            n = n + 3'd1;
            res[n[1:0]] = mk_res(KIND_END, 8'h00, (c == CH_DOT) ? TOK_DOT : TOK_PLUS,
                                 1'b0, 1'b1);
            n = n + 3'd1;
          end else begin
            held_nxt = c;
            mode_nxt = M_HELD;
          end
        end else if (c == CH_MINUS) begin
          held_nxt = c;
          mode_nxt = M_HELD;
        end else if (is_digit(c)) begin
          mode_nxt = M_NUMBER;
          dot_nxt  = 1'b0;
          res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
          n = n + 3'd1;
        end else if (is_alpha(c)) begin
          sym_nxt = 1'b1;
          res[n[1:0]] = mk_res(KIND_TEXT, c, TOK_INTEGER, 1'b0, 1'b1);
          n = n + 3'd1;
        end else begin
          res[n[1:0]] = mk_res(KIND_ERROR, 8'h00, TOK_INTEGER, ERR_INVALID, 1'b1);
          n = n + 3'd1;
          mode_nxt = M_ERROR;
          sym_nxt  = 1'b0;
          held_nxt = '0;
          dot_nxt  = 1'b0;
        end
      end
    end

    if (is_end) begin
      line_nxt = '0;
      col_nxt  = '0;
    end else if (counted) begin
      line_nxt = line_cnt;
      col_nxt  = col_cnt;
    end else begin
      line_nxt = line_r;
      col_nxt  = col_r;
    end

    push             = take && (n != 3'd0);
    bundle.last_idx  = 2'(n - 3'd1);
    bundle.res       = res;
    bundle.line_pre  = LINE_OUT_W'(line_r);
    bundle.col_pre   = COL_OUT_W'(col_r);
    bundle.line_post = LINE_OUT_W'(line_nxt);
    bundle.col_post  = COL_OUT_W'(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      sym_r  <= 1'b0;
      held_r <= '0;
      dot_r  <= 1'b0;
      line_r <= '0;
      col_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      sym_r  <= sym_nxt;
      held_r <= held_nxt;
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ----- src/ast_queue.sv -----
// ----------------------------------------------------------------------------
// ast_queue
// Short FIFO of result bundles between the lexer and the output stage.
// ----------------------------------------------------------------------------
module ast_queue
  import ast_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bundle_t       mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- src/ast_back.sv -----
// ----------------------------------------------------------------------------
// ast_back
// Output stage: walks the head bundle and presents one result per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module ast_back
  import ast_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  bundle_t               head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_text_byte,
  output logic [2:0]            out_token_kind,
  output logic                  out_error_code,
  output logic [LINE_OUT_W-1:0] out_line_number,
  output logic [COL_OUT_W-1:0]  out_column_number,
  output logic                  out_last
);

  logic                  valid_r;
  logic [1:0]            idx_r;
  logic [1:0]            kind_r;
  logic [7:0]            text_r;
  logic [2:0]            tok_r;
  logic                  ec_r;
  logic [LINE_OUT_W-1:0] line_r;
  logic [COL_OUT_W-1:0]  col_r;
  logic                  last_r;
  logic                  load;
  logic                  at_last;
  res_t                  cur;

  assign cur     = head.res[idx_r];
  assign at_last = (idx_r == head.last_idx);
  assign load    = !empty && (!valid_r || out_ready);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cur.kind;
      text_r <= cur.text;
      tok_r  <= cur.tok;
      ec_r   <= cur.ec;
      line_r <= cur.post ? head.line_post : head.line_pre;
      col_r  <= cur.post ? head.col_post : head.col_pre;
      last_r <= at_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_text_byte     = text_r;
  assign out_token_kind    = tok_r;
  assign out_error_code    = ec_r;
  assign out_line_number   = line_r;
  assign out_column_number = col_r;
  assign out_last          = last_r;

endmodule

// ----- src/assembly_source_tokenizer.sv -----
// The results of a byte pass through the bundle queue and then the output register.
// Throughput: one byte per cycle while the bundle queue has room; the output stage
//   sends one result per cycle while out_ready is high, the results of a byte in turn.
// The four-entry bundle queue absorbs bursts of up to four results per byte.
// Reset: synchronous, active low; clears the lexer mode, counters, queue and output valid.
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// Byte-serial lexer for assembly source: text bytes, token ends, errors, done.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer
  import ast_pkg::*;
#(
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel: one source byte per item
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char_byte,
  input  logic                  in_end_of_input,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_text_byte,
  output logic [2:0]            out_token_kind,
  output logic                  out_error_code,
  output logic [LINE_OUT_W-1:0] out_line_number,
  output logic [COL_OUT_W-1:0]  out_column_number,
  output logic                  out_last
);

  logic    take;
  logic    push;
  logic    pop;
  logic    q_empty;
  logic    q_full;
  bundle_t push_bundle;
  bundle_t head_bundle;

  // Take a byte whenever the queue can hold its bundle; the lexer state
  // advances on every taken byte, even one that produces no result.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Front end: lexer state, counters and classification. Builds all the
  // results of one byte at once, tagging each with the counter snapshot
  // (before or after the byte is counted) it must report.
  ast_front #(
    .LINE_WIDTH  (LINE_WIDTH),
    .COLUMN_WIDTH(COLUMN_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .char_byte   (in_char_byte),
    .end_of_input(in_end_of_input),
    .push        (push),
    .bundle      (push_bundle)
  );

  // Bundle queue: decouples the lexer from a stalled result consumer.
  ast_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_bundle),
    .pop      (pop),
    .head     (head_bundle),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end: serialize each bundle through the output register; pop the
  // bundle as its final result is loaded.
  ast_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head_bundle),
    .empty            (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_text_byte    (out_text_byte),
    .out_token_kind   (out_token_kind),
    .out_error_code   (out_error_code),
    .out_line_number  (out_line_number),
    .out_column_number(out_column_number),
    .out_last         (out_last)
  );

endmodule
